FILE: design/tkre_pkg.sv
// ----------------------------------------------------------------------------
// tkre_pkg
// Shared types and constants of the typematic key repeat engine.
// ----------------------------------------------------------------------------
package tkre_pkg;

  // Default sizing
  localparam int unsigned DEF_HELD_SLOTS          = 8;
  localparam int unsigned DEF_MAX_REPEATS_PER_KEY = 8;

  // Results a single tick may produce
  localparam int unsigned RESULT_LIMIT = 64;

  // Field widths
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned PERIOD_W   = 10;
  localparam int unsigned NEED_W     = DELAY_W + 1;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = CFG_IDX_W'(1);

  // Configuration reset values
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = DELAY_W'(300);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16);

  typedef enum logic [1:0] {
    ACT_KEY       = 2'd0,
    ACT_TICK      = 2'd1,
    ACT_FLUSH_ONE = 2'd2,
    ACT_FLUSH_ALL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_DOWN   = 2'd0,
    EV_UP     = 2'd1,
    EV_REPEAT = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;  // input transfer allowed
    logic exec;      // single-shot key event / flush of one key
    logic step;      // one walk step over the held keys
    logic finish;    // release the held-back result marked last
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    in_valid;
    action_e in_action;
    logic    walk_more;  // a held key is still unvisited
    logic    out_free;   // output register can take a result
  } dp_status_t;

endpackage

FILE: design/tkre_if.sv
// ----------------------------------------------------------------------------
// tkre_if
// Valid/ready channels of the engine: input items, results, config writes.
// ----------------------------------------------------------------------------
interface tkre_item_if import tkre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CODE_W-1:0] key_code;
  logic              key_down;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, action, key_code, key_down, now_ms, input ready);
  modport sink   (input valid, action, key_code, key_down, now_ms, output ready);
endinterface

interface tkre_result_if import tkre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] out_code;
  logic [1:0]        event_kind;
  logic              no_slot;
  logic              last;

  modport source (output valid, out_code, event_kind, no_slot, last, input ready);
  modport sink   (input valid, out_code, event_kind, no_slot, last, output ready);
endinterface

interface tkre_cfg_if import tkre_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tkre_ctrl.sv
// ----------------------------------------------------------------------------
// tkre_ctrl
// Sequencer: takes an item, runs the single-shot or walk phase, then closes
// the item by releasing its final result.
// ----------------------------------------------------------------------------
module tkre_ctrl import tkre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          if (status_i.in_action == ACT_KEY || status_i.in_action == ACT_FLUSH_ONE) begin
            state_d = ST_EXEC;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_EXEC: begin
        // hold stage is empty here, so no output stall applies
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_WALK: begin
        if (!status_i.walk_more) begin
          state_d = ST_FINISH;
        end else if (status_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/tkre_datapath.sv
// ----------------------------------------------------------------------------
// tkre_datapath
// Config registers, held-key slots, ordered walk, repeat timing, and a
// hold stage plus output register for the result stream.
// ----------------------------------------------------------------------------
module tkre_datapath import tkre_pkg::*; #(
  parameter int unsigned HELD_SLOTS          = DEF_HELD_SLOTS,
  parameter int unsigned MAX_REPEATS_PER_KEY = DEF_MAX_REPEATS_PER_KEY
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tkre_cfg_if.sink        cfg_i,
  tkre_item_if.sink       in_i,
  tkre_result_if.source   out_o,
  input  ctrl_cmd_t       cmd_i,
  output dp_status_t      status_o
);

  localparam int unsigned REP_W = $clog2(MAX_REPEATS_PER_KEY + 1);
  localparam int unsigned CNT_W = $clog2(RESULT_LIMIT + 1);

  // Configuration
  logic [DELAY_W-1:0]  delay_q;
  logic [PERIOD_W-1:0] period_q;

  // Latched item
  action_e             act_q;
  logic [CODE_W-1:0]   key_q;
  logic                down_q;
  logic [TIME_W-1:0]   now_q;
  logic [NEED_W-1:0]   need_q;
  logic [PERIOD_W-1:0] step_q;

  // Slots
  logic [HELD_SLOTS-1:0] valid_q, valid_d;
  logic [CODE_W-1:0]     code_q [HELD_SLOTS];
  logic [TIME_W-1:0]     time_q [HELD_SLOTS];

  // Walk state
  logic [HELD_SLOTS-1:0] done_q, done_d;
  logic [REP_W-1:0]      rep_q, rep_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Hold stage and output register
  logic              hold_valid_q;
  logic [CODE_W-1:0] hold_code_q;
  kind_e             hold_kind_q;
  logic              hold_noslot_q;
  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;
  kind_e             out_kind_q;
  logic              out_noslot_q;
  logic              out_last_q;

  logic                  in_xfer;
  logic [PERIOD_W-1:0]   period_eff;
  logic [HELD_SLOTS-1:0] pending, sel, match, free_first, target, key_wr, bump;
  logic [CODE_W-1:0]     sel_code;
  logic [TIME_W-1:0]     sel_time, elapsed;
  logic                  hit, rep_ok;
  logic                  emit_en, emit_noslot;
  logic [CODE_W-1:0]     emit_code;
  kind_e                 emit_kind;

  assign in_xfer    = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  // A zero period behaves as one millisecond
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

  // Ordered walk: pick the unvisited held key whose code is lowest.
  // Held codes are distinct, so exactly one wins when any is pending.
  assign pending = valid_q & ~done_q;

  always_comb begin
    for (int i = 0; i < HELD_SLOTS; i++) begin
      sel[i] = pending[i];
      for (int j = 0; j < HELD_SLOTS; j++) begin
        if (j != i && pending[j] && code_q[j] < code_q[i]) begin
          sel[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    sel_code = '0;
    sel_time = '0;
    for (int i = 0; i < HELD_SLOTS; i++) begin
      if (sel[i]) begin
        sel_code = sel_code | code_q[i];
        sel_time = sel_time | time_q[i];
      end
    end
  end

  // Repeat due check, modulo 2^32
  assign elapsed = now_q - sel_time;
  assign hit     = elapsed >= TIME_W'(need_q);
  assign rep_ok  = hit && (rep_q < REP_W'(MAX_REPEATS_PER_KEY)) &&
                   (cnt_q < CNT_W'(RESULT_LIMIT));

  // Key lookup and lowest free slot
  always_comb begin
    for (int i = 0; i < HELD_SLOTS; i++) begin
      match[i] = valid_q[i] && (code_q[i] == key_q);
    end
  end
  assign free_first = ~valid_q & (valid_q + HELD_SLOTS'(1));
  assign target     = (|match) ? match : free_first;

  // Slot and walk updates, result to emit
  always_comb begin
    valid_d     = valid_q;
    done_d      = done_q;
    rep_d       = rep_q;
    cnt_d       = cnt_q;
    key_wr      = '0;
    bump        = '0;
    emit_en     = 1'b0;
    emit_code   = key_q;
    emit_kind   = EV_UP;
    emit_noslot = 1'b0;
    if (in_xfer) begin
      done_d = '0;
      rep_d  = '0;
      cnt_d  = '0;
    end else if (cmd_i.exec) begin
      if (act_q == ACT_KEY && down_q) begin
        key_wr      = target;
        valid_d     = valid_q | target;
        emit_en     = 1'b1;
        emit_kind   = EV_DOWN;
        emit_noslot = ~|target;
      end else if (act_q == ACT_KEY) begin
        valid_d = valid_q & ~match;
        emit_en = 1'b1;
      end else if (|match) begin
        // flush of one key that is held
        valid_d = valid_q & ~match;
        emit_en = 1'b1;
      end
    end else if (cmd_i.step && (|pending)) begin
      emit_code = sel_code;
      if (act_q == ACT_FLUSH_ALL) begin
        valid_d = valid_q & ~sel;
        emit_en = 1'b1;
      end else if (rep_ok) begin
        bump      = sel;
        emit_en   = 1'b1;
        emit_kind = EV_REPEAT;
        rep_d     = rep_q + REP_W'(1);
        cnt_d     = cnt_q + CNT_W'(1);
      end else begin
        done_d = done_q | sel;
        rep_d  = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q      <= DELAY_RESET;
      period_q     <= PERIOD_RESET;
      valid_q      <= '0;
      done_q       <= '0;
      rep_q        <= '0;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_REPEAT_DELAY) begin
          delay_q <= cfg_i.data[DELAY_W-1:0];
        end else if (cfg_i.index == CFG_REPEAT_PERIOD) begin
          period_q <= cfg_i.data[PERIOD_W-1:0];
        end
      end
      valid_q <= valid_d;
      done_q  <= done_d;
      rep_q   <= rep_d;
      cnt_q   <= cnt_d;
      if (emit_en) begin
        hold_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        hold_valid_q <= 1'b0;
      end
      if ((emit_en || cmd_i.finish) && hold_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, slot and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q  <= action_e'(in_i.action);
      key_q  <= in_i.key_code;
      down_q <= in_i.key_down;
      now_q  <= in_i.now_ms;
      need_q <= NEED_W'(delay_q) + NEED_W'(period_eff);
      step_q <= period_eff;
    end
    for (int i = 0; i < HELD_SLOTS; i++) begin
      if (key_wr[i]) begin
        code_q[i] <= key_q;
        time_q[i] <= now_q;
      end else if (bump[i]) begin
        time_q[i] <= time_q[i] + TIME_W'(step_q);
      end
    end
    if (emit_en) begin
      hold_code_q   <= emit_code;
      hold_kind_q   <= emit_kind;
      hold_noslot_q <= emit_noslot;
    end
    // the held-back result is last only when the item closes
    if ((emit_en || cmd_i.finish) && hold_valid_q) begin
      out_code_q   <= hold_code_q;
      out_kind_q   <= hold_kind_q;
      out_noslot_q <= hold_noslot_q;
      out_last_q   <= cmd_i.finish;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_code   = out_code_q;
  assign out_o.event_kind = out_kind_q;
  assign out_o.no_slot    = out_noslot_q;
  assign out_o.last       = out_last_q;

  assign status_o.in_valid  = in_i.valid;
  assign status_o.in_action = action_e'(in_i.action);
  assign status_o.walk_more = |pending;
  assign status_o.out_free  = !out_valid_q || out_o.ready;

endmodule

FILE: design/typematic_key_repeat_engine_top.sv
// ----------------------------------------------------------------------------
// typematic_key_repeat_engine_top
// Held-key tracker that reports down, up and timed repeat events.
// ----------------------------------------------------------------------------
// One item is in work at a time; a key event or a flush of one key runs a
// single-shot phase, while a flush of all keys or a tick walks the held keys.
// A tick reports at most HELD_SLOTS * MAX_REPEATS_PER_KEY repeats, capped at
// 64. The walk visits held keys in ascending scan code, one slot check or one
// repeat per cycle while the result consumer does not stall the output
// register, through a single 32-bit elapsed-time compare. Configuration
// writes are taken in any cycle and should be issued only while the engine
// is idle.
// ----------------------------------------------------------------------------
module typematic_key_repeat_engine_top import tkre_pkg::*; #(
  parameter int unsigned HELD_SLOTS          = DEF_HELD_SLOTS,
  parameter int unsigned MAX_REPEATS_PER_KEY = DEF_MAX_REPEATS_PER_KEY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tkre_cfg_if.sink      cfg_i,
  tkre_item_if.sink     in_i,
  tkre_result_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tkre_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tkre_datapath #(
    .HELD_SLOTS          (HELD_SLOTS),
    .MAX_REPEATS_PER_KEY (MAX_REPEATS_PER_KEY)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

FILE: design/tkre_checker.sv
// ----------------------------------------------------------------------------
// tkre_checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module tkre_checker import tkre_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CODE_W-1:0] out_code_i,
  input logic [1:0]        event_kind_i,
  input logic              no_slot_i,
  input logic              last_i
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_code_i) &&
    $stable(event_kind_i) && $stable(no_slot_i) && $stable(last_i))
    else $error("result changed while stalled");

  // One item at a time: no input transfer right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // Untracked flag appears only on down events
  a_noslot_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && no_slot_i |-> event_kind_i == EV_DOWN)
    else $error("no_slot on a result that is not down");

  // A down event is the only result of its key event
  a_down_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == EV_DOWN |-> last_i)
    else $error("down result not marked last");

endmodule

bind typematic_key_repeat_engine_top tkre_checker u_tkre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_code_i   (out_o.out_code),
  .event_kind_i (out_o.event_kind),
  .no_slot_i    (out_o.no_slot),
  .last_i       (out_o.last)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typematic key repeat engine. A directed pass
// covers press, release, repeat timing, the per-key repeat cap, a full table,
// flushes and time wrap. Randomized key traffic then runs under several repeat
// timings, with random stalls on both channels. A behavioral copy of the key
// table predicts every down, up and repeat event, and each result transfer is
// checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tkre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HELD       = DEF_HELD_SLOTS;
  localparam int unsigned MAX_REP    = DEF_MAX_REPEATS_PER_KEY;
  localparam int unsigned SETTLE_CYC = 200;   // worst tick walk plus stalls
  localparam int unsigned DOG_LIMIT  = 3000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYC  = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    kind_e             kind;
    logic              no_slot;
    logic              last;
  } evt_t;

  logic clk_i;
  logic rst_ni;

  tkre_item_if   item_bus ();
  tkre_result_if evt_bus ();
  tkre_cfg_if    cfg_bus ();

  typematic_key_repeat_engine_top #(
    .HELD_SLOTS          (HELD),
    .MAX_REPEATS_PER_KEY (MAX_REP)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (item_bus),
    .out_o  (evt_bus)
  );

  // Predicted key table and timing registers
  logic               held_on   [HELD];
  logic [CODE_W-1:0]  held_code [HELD];
  logic [TIME_W-1:0]  held_ms   [HELD];
  logic [DELAY_W-1:0] cfg_delay;
  logic [PERIOD_W-1:0] cfg_period;

  evt_t pending_evts [$];

  int err_cnt   = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_down    = 0;
  int n_up      = 0;
  int n_repeat  = 0;
  int n_noslot  = 0;
  int n_writes  = 0;
  int dog_cnt   = 0;
  bit calm      = 1'b0;
  logic [TIME_W-1:0] ms_now = '0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  function automatic int find_held(input logic [CODE_W-1:0] code);
    for (int i = 0; i < HELD; i++)
      if (held_on[i] && held_code[i] == code) return i;
    return -1;
  endfunction

  // Append one event at the tail of a queue
  function automatic void add_evt(ref evt_t q [$], input evt_t e);
    q.insert(q.size(), e);
  endfunction

  // Work out the events one input item causes and queue them
  function automatic void predict_events(input action_e act, input logic [CODE_W-1:0] code,
                                         input logic down, input logic [TIME_W-1:0] now);
    evt_t batch [$];
    int s;
    int reps;
    logic [TIME_W-1:0] step_ms;
    logic [TIME_W-1:0] need_ms;
    s = find_held(code);
    case (act)
      ACT_KEY: begin
        if (down) begin
          if (s < 0) begin
            for (int i = 0; i < HELD; i++)
              if (!held_on[i] && s < 0) s = i;
          end
          if (s >= 0) begin
            held_on[s]   = 1'b1;
            held_code[s] = code;
            held_ms[s]   = now;
            add_evt(batch, evt_t'{code, EV_DOWN, 1'b0, 1'b0});
          end else begin
            add_evt(batch, evt_t'{code, EV_DOWN, 1'b1, 1'b0});
          end
        end else begin
          if (s >= 0) held_on[s] = 1'b0;
          add_evt(batch, evt_t'{code, EV_UP, 1'b0, 1'b0});
        end
      end
      ACT_FLUSH_ONE: begin
        if (s >= 0) begin
          held_on[s] = 1'b0;
          add_evt(batch, evt_t'{code, EV_UP, 1'b0, 1'b0});
        end
      end
      ACT_FLUSH_ALL: begin
        // codes are unique in the table, so a code sweep gives ascending order
        for (int c = 0; c < 256; c++) begin
          s = find_held(CODE_W'(c));
          if (s >= 0) begin
            add_evt(batch, evt_t'{CODE_W'(c), EV_UP, 1'b0, 1'b0});
            held_on[s] = 1'b0;
          end
        end
      end
      default: begin
        step_ms = (cfg_period == '0) ? TIME_W'(1) : TIME_W'(cfg_period);
        need_ms = TIME_W'(cfg_delay) + step_ms;
        for (int c = 0; c < 256; c++) begin
          s = find_held(CODE_W'(c));
          if (s >= 0) begin
            reps = 0;
            while (reps < MAX_REP && batch.size() < RESULT_LIMIT &&
                   TIME_W'(now - held_ms[s]) >= need_ms) begin
              add_evt(batch, evt_t'{CODE_W'(c), EV_REPEAT, 1'b0, 1'b0});
              held_ms[s] = held_ms[s] + step_ms;
              reps++;
            end
          end
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) add_evt(pending_evts, batch[i]);
  endfunction

  // Result check, input prediction and register tracking, all at the edge
  always @(posedge clk_i) begin : monitor
    evt_t want;
    if (!rst_ni) begin
      for (int i = 0; i < HELD; i++) held_on[i] = 1'b0;
      cfg_delay  <= DELAY_RESET;
      cfg_period <= PERIOD_RESET;
    end else begin
      if (evt_bus.valid === 1'b1 && evt_bus.ready === 1'b1) begin
        n_results++;
        case (evt_bus.event_kind)
          EV_DOWN:   n_down++;
          EV_UP:     n_up++;
          EV_REPEAT: n_repeat++;
          default: ;
        endcase
        if (evt_bus.no_slot === 1'b1) n_noslot++;
        if (pending_evts.size() == 0) begin
          report_mismatch($sformatf("unexpected result code %02h kind %0d",
                                    evt_bus.out_code, evt_bus.event_kind));
        end else begin
          want = pending_evts.pop_front();
          if (evt_bus.out_code !== want.code)
            report_mismatch($sformatf("out_code %02h, want %02h", evt_bus.out_code, want.code));
          if (evt_bus.event_kind !== want.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d (code %02h)",
                                      evt_bus.event_kind, want.kind, want.code));
          if (evt_bus.no_slot !== want.no_slot)
            report_mismatch($sformatf("no_slot %b, want %b (code %02h)",
                                      evt_bus.no_slot, want.no_slot, want.code));
          if (evt_bus.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (code %02h)",
                                      evt_bus.last, want.last, want.code));
        end
      end
      if (item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
        predict_events(action_e'(item_bus.action), item_bus.key_code,
                       item_bus.key_down, item_bus.now_ms);
      if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) begin
        if (cfg_bus.index == CFG_REPEAT_DELAY)
          cfg_delay <= cfg_bus.data[DELAY_W-1:0];
        else if (cfg_bus.index == CFG_REPEAT_PERIOD)
          cfg_period <= cfg_bus.data[PERIOD_W-1:0];
      end
    end
  end

  // Result consumer with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      evt_bus.ready <= 1'b0;
    end else begin
      evt_bus.ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni ||
        (item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (evt_bus.valid === 1'b1 && evt_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      dog_cnt <= 0;
    end else if (dog_cnt >= DOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               dog_cnt, pending_evts.size());
      $display("tb: failure");
      $finish;
    end else begin
      dog_cnt <= dog_cnt + 1;
    end
  end

  // One input transfer; valid stays high so back-to-back items need no edge
  task automatic send_item(input action_e act, input logic [CODE_W-1:0] code,
                           input logic down, input logic [TIME_W-1:0] now);
    if (!calm && $urandom_range(0, 99) < 10) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    item_bus.valid    <= 1'b1;
    item_bus.action   <= act;
    item_bus.key_code <= code;
    item_bus.key_down <= down;
    item_bus.now_ms   <= now;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    n_items++;
  endtask

  task automatic input_idle();
    item_bus.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_evts.size() != 0) @(posedge clk_i);
  endtask

  // Idle the engine, then write both timing registers
  task automatic set_timing(input logic [CFG_DATA_W-1:0] delay,
                            input logic [CFG_DATA_W-1:0] period_word,
                            input bit poke_unused);
    input_idle();
    wait_drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_REPEAT_DELAY;
    cfg_bus.data  <= delay;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    n_writes++;
    if (poke_unused) begin
      cfg_bus.index <= CFG_UNUSED;
      cfg_bus.data  <= CFG_DATA_W'($urandom);
      do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
      n_writes++;
    end
    cfg_bus.index <= CFG_REPEAT_PERIOD;
    cfg_bus.data  <= period_word;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    n_writes++;
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset timing: first repeat at delay + period, restart on re-press,
  // per-key cap with carry-over to the next tick, release of an unheld key
  task automatic test_press_and_repeat();
    send_item(ACT_KEY, 8'h00, 1'b1, 32'd1000);
    send_item(ACT_KEY, 8'hFF, 1'b1, 32'd1000);
    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 32'd1315);
    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 32'd1316);
    send_item(ACT_KEY, 8'h00, 1'b1, 32'd1316);
    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 32'd1508);
    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 32'd1508);
    send_item(ACT_KEY, 8'h00, 1'b0, 32'd1510);
    send_item(ACT_KEY, 8'h42, 1'b0, 32'd1510);
  endtask

  // Fill the table; the next new key is reported untracked and never repeats
  task automatic test_table_full();
    for (int i = 0; i < HELD - 1; i++)
      send_item(ACT_KEY, CODE_W'(8'h10 + i), 1'b1, 32'd2000);
    send_item(ACT_KEY, 8'h80, 1'b1, 32'd2000);
  endtask

  // Flush of an unheld key, of a held key, of all keys, and of an empty table
  task automatic test_flush();
    send_item(ACT_FLUSH_ONE, 8'h99, 1'($urandom), 32'($urandom));
    send_item(ACT_FLUSH_ONE, 8'h10, 1'($urandom), 32'($urandom));
    send_item(ACT_FLUSH_ALL, 8'($urandom), 1'($urandom), 32'($urandom));
    send_item(ACT_FLUSH_ALL, 8'($urandom), 1'($urandom), 32'($urandom));
  endtask

  // Elapsed time across the 2^32 wrap of the millisecond counter
  task automatic test_time_wrap();
    send_item(ACT_KEY, 8'h55, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 32'h0000_013B);
    send_item(ACT_FLUSH_ALL, 8'($urandom), 1'($urandom), 32'h0000_0000);
  endtask

  // Zero delay with a zero period, which behaves as a period of one
  task automatic test_zero_period();
    set_timing('0, '0, 1'b0);
    send_item(ACT_KEY, 8'h33, 1'b1, 32'd5000);
    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 32'd5003);
    send_item(ACT_FLUSH_ALL, 8'($urandom), 1'($urandom), 32'd5003);
    ms_now = 32'd6000;
  endtask

  // Mostly well-formed key traffic over a small code pool, plus noise
  task automatic test_random_traffic(input int count, input bit quiet);
    logic [CODE_W-1:0] pool [12];
    int pick;
    int step_ms;
    int need_ms;
    calm = quiet;
    foreach (pool[i]) pool[i] = CODE_W'($urandom_range(0, 255));
    step_ms = (cfg_period == '0) ? 1 : int'(cfg_period);
    need_ms = int'(cfg_delay) + step_ms;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 4) begin
        input_idle();
        wait_drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        ms_now += $urandom_range(0, 3);
        send_item(ACT_KEY, pool[$urandom_range(0, 11)],
                  1'($urandom_range(0, 99) < 60), ms_now);
      end else if (pick < 75) begin
        ms_now += $urandom_range(0, need_ms + 4 * step_ms);
        send_item(ACT_TICK, 8'($urandom), 1'($urandom), ms_now);
      end else if (pick < 85) begin
        send_item(ACT_FLUSH_ONE, pool[$urandom_range(0, 11)], 1'($urandom), ms_now);
      end else if (pick < 90) begin
        send_item(ACT_FLUSH_ALL, 8'($urandom), 1'($urandom), ms_now);
      end else begin
        send_item(action_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 32'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  // Test sequence
  initial begin
    rst_ni            <= 1'b0;
    item_bus.valid    <= 1'b0;
    item_bus.action   <= ACT_KEY;
    item_bus.key_code <= '0;
    item_bus.key_down <= 1'b0;
    item_bus.now_ms   <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_REPEAT_DELAY;
    cfg_bus.data      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_press_and_repeat();
    test_table_full();
    test_flush();
    test_time_wrap();
    test_zero_period();

    set_timing(16'd20, 16'd5, 1'b0);
    test_random_traffic(75, 1'b0);
    set_timing(16'd0, 16'd1, 1'b0);
    test_random_traffic(70, 1'b1);
    set_timing(16'hFFFF, 16'd1023, 1'b1);
    test_random_traffic(50, 1'b0);
    set_timing(CFG_DATA_W'($urandom_range(0, 2000)),
               CFG_DATA_W'($urandom_range(0, 1023)), 1'b0);
    test_random_traffic(50, 1'b0);
    // upper bits of the period word must be dropped
    set_timing(CFG_DATA_W'($urandom), {6'h3F, 10'($urandom)}, 1'b1);
    test_random_traffic(70, 1'b0);
    set_timing(DELAY_RESET, CFG_DATA_W'(PERIOD_RESET), 1'b0);
    test_random_traffic(30, 1'b0);

    input_idle();
    wait_drain();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (pending_evts.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", pending_evts.size()));

    $display("run covered %0d items, %0d results: %0d down (%0d untracked), %0d up, %0d repeat",
             n_items, n_results, n_down, n_noslot, n_up, n_repeat);
    $display("%0d register writes, %0d mismatches", n_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tkre_pkg.sv
design/tkre_if.sv
design/tkre_ctrl.sv
design/tkre_datapath.sv
design/typematic_key_repeat_engine_top.sv
design/tkre_checker.sv
sim/tb_top.sv
